### hw/rtl/bmftl_pkg.sv
// shared types and constants for the block-mapped flash translation controller
// request and flash command transaction layouts, command codes, default sizes
package bmftl_pkg;

  localparam int SECTOR_W = 7;
  localparam int PAGE_W   = 7;
  localparam int ERASE_W  = 5;
  localparam int CMD_W    = 3;

  localparam int PAGES_IN_BLOCK_DEF = 4;
  localparam int LOGICAL_BLOCKS_DEF = 31;

  localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROGRAM = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COPY    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NODATA  = 3'd4;

  typedef struct packed {
    logic                req_type;
    logic [SECTOR_W-1:0] sector_number;
  } req_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PAGE_W-1:0]  target_page;
    logic [PAGE_W-1:0]  source_page;
    logic [ERASE_W-1:0] erase_block_index;
    logic               last;
  } flash_cmd_t;

endpackage

### hw/rtl/bmftl_map_mem.sv
// logical-to-physical block map memory, one write and one read port
// registered read data with read enable; no dependencies
module bmftl_map_mem #(
  parameter int DEPTH = 31,
  parameter int WIDTH = 6,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bmftl_page_mem.sv
// page written bits, one row of page bits per physical block
// registered read data with read enable; no dependencies
module bmftl_page_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] row_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= row_mem[raddr];
    end
  end

endmodule

### hw/rtl/block_mapped_ftl_controller.sv
// block-mapped flash translation controller: request sequencer and output register
// uses bmftl_pkg, bmftl_map_mem and bmftl_page_mem
//
// Each request transaction names a logical sector and produces one or more flash
// command transactions, the final one flagged by last. Requests are handled one at a
// time by a sequencer that reads, updates and writes back two memories with one write
// and one read port each: the block map (one entry per logical block) and the page
// written bits (one row per physical block). An out-of-range sector, or a read that
// finds its block unmapped, is answered after the map read alone; any other read and
// a write to a clean page also read the page row; an overwrite of a written page then
// walks every page of the block in a copy to the spare block and ends with an erase.
// The command side can stall any of these. After reset a clearing pass zeroes both
// memories before the first request is accepted.
module block_mapped_ftl_controller #(
  parameter int PAGES_IN_BLOCK = bmftl_pkg::PAGES_IN_BLOCK_DEF,
  parameter int LOGICAL_BLOCKS = bmftl_pkg::LOGICAL_BLOCKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  bmftl_pkg::req_t        req,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output bmftl_pkg::flash_cmd_t  cmd
);

  import bmftl_pkg::*;

  localparam int PHYS_BLOCKS = LOGICAL_BLOCKS + 1;
  localparam int BLK_W = $clog2(PHYS_BLOCKS);
  localparam int LBN_W = (LOGICAL_BLOCKS > 1) ? $clog2(LOGICAL_BLOCKS) : 1;
  localparam int OFS_W = $clog2(PAGES_IN_BLOCK);
  localparam int PPN_W = $clog2(PHYS_BLOCKS * PAGES_IN_BLOCK);
  localparam int SHIFT = 2 * SECTOR_W;
  localparam int RECIP = ((2 ** SHIFT) + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;
  localparam int PROD_W = SECTOR_W + SHIFT;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAP   = 3'd2;
  localparam logic [2:0] ST_ROW   = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_ERASE = 3'd5;

  logic [2:0]                state, state_next;
  logic [BLK_W-1:0]          clr_cnt;
  logic                      is_write;
  logic                      oor;
  logic [LBN_W-1:0]          lbn;
  logic [OFS_W-1:0]          offset;
  logic [BLK_W-1:0]          pbn, pbn_next;
  logic [PAGES_IN_BLOCK-1:0] row, row_next;
  logic [OFS_W-1:0]          idx, idx_next;
  logic [BLK_W-1:0]          spare, spare_next;
  logic [PPN_W-1:0]          base_src, base_src_next;
  logic [PPN_W-1:0]          base_dst, base_dst_next;

  logic [PROD_W-1:0]         quo_prod;
  logic [SECTOR_W-1:0]       quo;
  logic [OFS_W-1:0]          rem;
  logic                      quo_oor;
  logic                      accept;
  logic                      out_free;
  logic                      emit;
  flash_cmd_t                emit_cmd;

  logic                      map_we, map_re;
  logic [LBN_W-1:0]          map_waddr, map_raddr;
  logic [BLK_W:0]            map_wdata, map_rdata;
  logic                      pg_we, pg_re;
  logic [BLK_W-1:0]          pg_waddr, pg_raddr;
  logic [PAGES_IN_BLOCK-1:0] pg_wdata, pg_rdata;

  logic                      mapped;
  logic [BLK_W-1:0]          pbn_sel;
  logic [PPN_W-1:0]          ppn;
  logic [PPN_W-1:0]          copy_src, copy_dst;

  bmftl_map_mem #(
    .DEPTH (LOGICAL_BLOCKS),
    .WIDTH (BLK_W + 1),
    .ADDR_W(LBN_W)
  ) u_map_mem (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .re   (map_re),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  bmftl_page_mem #(
    .DEPTH (PHYS_BLOCKS),
    .WIDTH (PAGES_IN_BLOCK),
    .ADDR_W(BLK_W)
  ) u_page_mem (
    .clk  (clk),
    .we   (pg_we),
    .waddr(pg_waddr),
    .wdata(pg_wdata),
    .re   (pg_re),
    .raddr(pg_raddr),
    .rdata(pg_rdata)
  );

  // sector split into logical block and page offset by reciprocal multiply
  assign quo_prod = PROD_W'(req.sector_number) * PROD_W'(RECIP);
  assign quo      = quo_prod[SHIFT +: SECTOR_W];
  assign rem      = OFS_W'(req.sector_number - SECTOR_W'(quo * SECTOR_W'(PAGES_IN_BLOCK)));
  assign quo_oor  = (int'(quo) >= LOGICAL_BLOCKS);

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !cmd_valid || cmd_ready;

  assign mapped   = map_rdata[BLK_W];
  assign pbn_sel  = mapped ? map_rdata[BLK_W-1:0] : BLK_W'(lbn);
  assign ppn      = PPN_W'(int'(pbn) * PAGES_IN_BLOCK + int'(offset));
  assign copy_src = base_src + PPN_W'(idx);
  assign copy_dst = base_dst + PPN_W'(idx);

  always_comb begin
    state_next    = state;
    pbn_next      = pbn;
    row_next      = row;
    idx_next      = idx;
    spare_next    = spare;
    base_src_next = base_src;
    base_dst_next = base_dst;
    map_we        = 1'b0;
    map_waddr     = lbn;
    map_wdata     = '0;
    map_re        = 1'b0;
    map_raddr     = LBN_W'(quo);
    pg_we         = 1'b0;
    pg_waddr      = pbn;
    pg_wdata      = '0;
    pg_re         = 1'b0;
    pg_raddr      = pbn_sel;
    emit          = 1'b0;
    emit_cmd      = '0;

    case (state)
      ST_CLEAR: begin
        pg_we    = 1'b1;
        pg_waddr = clr_cnt;
        if (int'(clr_cnt) < LOGICAL_BLOCKS) begin
          map_we    = 1'b1;
          map_waddr = LBN_W'(clr_cnt);
        end
        if (clr_cnt == BLK_W'(PHYS_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          map_re     = !quo_oor;
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (oor || (!is_write && !mapped)) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_cmd.command = CMD_NODATA;
            emit_cmd.last    = 1'b1;
            state_next       = ST_IDLE;
          end
        end else begin
          pg_re    = 1'b1;
          pbn_next = pbn_sel;
          if (is_write && !mapped) begin
            map_we    = 1'b1;
            map_wdata = {1'b1, pbn_sel};
          end
          state_next = ST_ROW;
        end
      end
      ST_ROW: begin
        if (!is_write) begin
          if (out_free) begin
            emit                 = 1'b1;
            emit_cmd.command     = pg_rdata[offset] ? CMD_READ : CMD_NODATA;
            emit_cmd.target_page = pg_rdata[offset] ? PAGE_W'(ppn) : '0;
            emit_cmd.last        = 1'b1;
            state_next           = ST_IDLE;
          end
        end else if (!pg_rdata[offset]) begin
          if (out_free) begin
            emit                 = 1'b1;
            emit_cmd.command     = CMD_PROGRAM;
            emit_cmd.target_page = PAGE_W'(ppn);
            emit_cmd.last        = 1'b1;
            pg_we                = 1'b1;
            pg_wdata             = pg_rdata | (PAGES_IN_BLOCK'(1) << offset);
            state_next           = ST_IDLE;
          end
        end else begin
          // spare row ends with the same written pattern as the old block
          row_next      = pg_rdata;
          pg_we         = 1'b1;
          pg_waddr      = spare;
          pg_wdata      = pg_rdata;
          base_src_next = PPN_W'(int'(pbn) * PAGES_IN_BLOCK);
          base_dst_next = PPN_W'(int'(spare) * PAGES_IN_BLOCK);
          idx_next      = '0;
          state_next    = ST_COPY;
        end
      end
      ST_COPY: begin
        if ((idx == offset) || row[idx]) begin
          if (out_free) begin
            emit                 = 1'b1;
            emit_cmd.command     = (idx == offset) ? CMD_PROGRAM : CMD_COPY;
            emit_cmd.target_page = PAGE_W'(copy_dst);
            emit_cmd.source_page = (idx == offset) ? '0 : PAGE_W'(copy_src);
            idx_next             = idx + OFS_W'(1);
            if (idx == OFS_W'(PAGES_IN_BLOCK - 1)) begin
              state_next = ST_ERASE;
            end
          end
        end else begin
          idx_next = idx + OFS_W'(1);
          if (idx == OFS_W'(PAGES_IN_BLOCK - 1)) begin
            state_next = ST_ERASE;
          end
        end
      end
      ST_ERASE: begin
        if (out_free) begin
          emit                       = 1'b1;
          emit_cmd.command           = CMD_ERASE;
          emit_cmd.erase_block_index = ERASE_W'(pbn);
          emit_cmd.last              = 1'b1;
          pg_we                      = 1'b1;
          pg_wdata                   = '0;
          map_we                     = 1'b1;
          map_wdata                  = {1'b1, spare};
          spare_next                 = pbn;
          state_next                 = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      spare     <= BLK_W'(LOGICAL_BLOCKS);
      cmd_valid <= 1'b0;
    end else begin
      state   <= state_next;
      spare   <= spare_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + BLK_W'(1);
      end
      if (emit) begin
        cmd_valid <= 1'b1;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_write <= req.req_type;
      oor      <= quo_oor;
      lbn      <= LBN_W'(quo);
      offset   <= rem;
    end
    if (emit) begin
      cmd <= emit_cmd;
    end
    pbn      <= pbn_next;
    row      <= row_next;
    idx      <= idx_next;
    base_src <= base_src_next;
    base_dst <= base_dst_next;
  end

endmodule
